@@ design/mfwr_pkg.sv @@
`timescale 1ns / 1ps

package mfwr_pkg;

   // bank sizing
   localparam int MAX_WORDS  = 16;
   localparam int BANK_DEPTH = 2 * MAX_WORDS;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);

   // field widths
   localparam int WORD_W      = 32;
   localparam int LEN_W       = 5;
   localparam int IDX_FIELD_W = 4;

   // longest usable frame and the phase counter that covers it plus the wait for the end marker
   localparam int MAX_LEN = (MAX_WORDS < 31) ? MAX_WORDS : 31;
   localparam int PHASE_W = $clog2(MAX_LEN + 2);

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_MARKER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_MARKER   = 2'd2;

   localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = 5'd9;

   // beat command codes
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0]  frame_length;
      logic [WORD_W-1:0] start_marker;
      logic [WORD_W-1:0] end_marker;
   } cfg_type;

   // per-beat result flags that travel alongside the memory read
   typedef struct packed {
      logic rd_hit;
      logic index_error;
      logic frame_done;
      logic in_frame;
   } meta_type;

endpackage

@@ design/mfwr_req_if.sv @@
`timescale 1ns / 1ps

interface mfwr_req_if
   import mfwr_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [WORD_W-1:0]      sample_word;
   logic [IDX_FIELD_W-1:0] read_index;

   modport source (output valid, cmd, sample_word, read_index, input ready);
   modport sink   (input valid, cmd, sample_word, read_index, output ready);
endinterface

@@ design/mfwr_rsp_if.sv @@
`timescale 1ns / 1ps

interface mfwr_rsp_if
   import mfwr_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_data;
   logic              index_error;
   logic              frame_done;
   logic              in_frame;

   modport source (output valid, read_data, index_error, frame_done, in_frame, input ready);
   modport sink   (input valid, read_data, index_error, frame_done, in_frame, output ready);
endinterface

@@ design/mfwr_ram.sv @@
`timescale 1ns / 1ps

module mfwr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/mfwr_csr.sv @@
`timescale 1ns / 1ps

module mfwr_csr
   import mfwr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);
   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_strobe;
   logic [CSR_IDX_W-1:0]   reg_idx;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_FRAME_LENGTH: cfg_in.frame_length = pwdata[LEN_W-1:0];
            REG_START_MARKER: cfg_in.start_marker = pwdata[WORD_W-1:0];
            REG_END_MARKER:   cfg_in.end_marker   = pwdata[WORD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length <= FRAME_LENGTH_RESET;
         cfg_ff.start_marker <= '0;
         cfg_ff.end_marker   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_FRAME_LENGTH: prdata = CSR_DATA_W'(cfg_ff.frame_length);
         REG_START_MARKER: prdata = CSR_DATA_W'(cfg_ff.start_marker);
         REG_END_MARKER:   prdata = CSR_DATA_W'(cfg_ff.end_marker);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

@@ design/mfwr_ctrl.sv @@
`timescale 1ns / 1ps

module mfwr_ctrl
   import mfwr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   accept,
   input  logic                   cmd,
   input  logic [WORD_W-1:0]      sample_word,
   input  logic [IDX_FIELD_W-1:0] read_index,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   output meta_type               meta
);
   logic [PHASE_W-1:0]    phase_ff;
   logic [PHASE_W-1:0]    phase_in;
   logic                  fill_ff;
   logic                  fill_in;
   logic [BANK_DEPTH-1:0] written_ff;
   logic [BANK_DEPTH-1:0] written_in;
   logic [LEN_W-1:0]      eff_len;
   logic                  rd_ok;

   // frame length saturates at the bank size
   assign eff_len = (int'(cfg.frame_length) > MAX_WORDS) ? LEN_W'(MAX_WORDS)
                                                         : cfg.frame_length;

   // addresses: fill bank for stores, the other bank for reads
   assign wr_addr = ADDR_W'(fill_ff) * ADDR_W'(MAX_WORDS) + ADDR_W'(phase_ff - 1'b1);
   assign rd_addr = ADDR_W'(~fill_ff) * ADDR_W'(MAX_WORDS) + ADDR_W'(read_index);
   assign rd_ok   = (int'(read_index) < int'(eff_len)) && (int'(read_index) < MAX_WORDS);

   // deframer step for the accepted beat
   always_comb begin
      phase_in         = phase_ff;
      fill_in          = fill_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      meta.rd_hit      = 1'b0;
      meta.index_error = 1'b0;
      meta.frame_done  = 1'b0;
      if (accept) begin
         if (cmd == CMD_SAMPLE) begin
            if (phase_ff == '0) begin
               if (sample_word == cfg.start_marker) begin
                  phase_in = PHASE_W'(1);
               end
            end else if (int'(phase_ff) <= int'(eff_len)) begin
               wr_en    = 1'b1;
               phase_in = phase_ff + 1'b1;
            end else if (sample_word == cfg.end_marker) begin
               phase_in        = '0;
               fill_in         = ~fill_ff;
               meta.frame_done = 1'b1;
            end
         end else begin
            // reads hit the bank opposite the one being stored, so no same-entry overlap
            rd_en            = rd_ok;
            meta.index_error = ~rd_ok;
            meta.rd_hit      = rd_ok && written_ff[rd_addr];
         end
      end
      meta.in_frame = (phase_in != '0);
   end

   // written marks stand in for the reset clear of both banks
   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         fill_ff    <= 1'b0;
         written_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         fill_ff    <= fill_in;
         written_ff <= written_in;
      end
   end
endmodule

@@ design/marker_framed_word_receiver_top.sv @@
`timescale 1ns / 1ps
// channel    direction  handshake      beat contents
// req_bus    in         valid/ready    cmd, sample_word, read_index
// rsp_bus    out        valid/ready    read_data, index_error, frame_done, in_frame
// csr (apb)  in         psel/penable   frame_length @0x0, start_marker @0x4, end_marker @0x8
//
// one beat per cycle sustained while rsp_bus is ready; a taken beat passes through the registered
// read port of the bank memory and then the output register before its result appears
// synchronous reset clears the phase, bank select and per-entry written marks
// stalls on rsp_bus fill the read stage and output register, then req_bus ready drops

module marker_framed_word_receiver_top
   import mfwr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mfwr_req_if.sink              req_bus,
   mfwr_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   cfg_type           cfg;
   logic              accept;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] ram_q;
   meta_type          meta;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   meta_type          s1_meta_ff;
   logic              out_free;
   logic              s1_adv;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff;
   logic              rsp_err_ff;
   logic              rsp_done_ff;
   logic              rsp_frame_ff;

   mfwr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mfwr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .cmd         (req_bus.cmd),
      .sample_word (req_bus.sample_word),
      .read_index  (req_bus.read_index),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .meta        (meta)
   );

   mfwr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BANK_DEPTH)
   ) u_banks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_bus.sample_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // pipeline flow: read stage holds the memory output until the output register frees
   assign out_free      = ~rsp_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_valid_ff && out_free;
   assign req_bus.ready = ~s1_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_adv) begin
         rsp_data_ff  <= s1_meta_ff.rd_hit ? ram_q : '0;
         rsp_err_ff   <= s1_meta_ff.index_error;
         rsp_done_ff  <= s1_meta_ff.frame_done;
         rsp_frame_ff <= s1_meta_ff.in_frame;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_data   = rsp_data_ff;
   assign rsp_bus.index_error = rsp_err_ff;
   assign rsp_bus.frame_done  = rsp_done_ff;
   assign rsp_bus.in_frame    = rsp_frame_ff;

`ifndef ASSERT_OFF
   // a stalled read stage keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_meta_ff))
      else $error("read stage lost a stalled beat");

   // an index error never carries data
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.index_error |-> rsp_bus.read_data == '0)
      else $error("index error with nonzero data");

   // a read beat flagged with an index error never closes a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.index_error && rsp_bus.frame_done))
      else $error("frame done on a read beat");

   // memory read only issued when the read stage can take it
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> accept ##1 s1_valid_ff)
      else $error("memory read without a tracking beat");
`endif
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import mfwr_pkg::*;
();

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;
   localparam int TAIL_CYCLES  = 8;
   localparam int BEAT_TARGET  = 850;
   localparam int POS_W        = $clog2(MAX_WORDS);

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              index_error;
      logic              frame_done;
      logic              in_frame;
   } word_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mfwr_req_if req_bus();
   mfwr_rsp_if rsp_bus();

   marker_framed_word_receiver_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // deframer state as predicted
   logic [LEN_W-1:0]   frame_len;
   logic [WORD_W-1:0]  start_word;
   logic [WORD_W-1:0]  end_word;
   logic [PHASE_W-1:0] rx_phase;
   logic               fill_sel;
   logic [WORD_W-1:0]  bank_words [2][MAX_WORDS];

   word_result_type expected_results[$];
   word_result_type oldest_result;

   bit req_idling   = 1'b0;
   bit rsp_idling   = 1'b0;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   int errors          = 0;
   int beats_sent      = 0;
   int ignored_beats   = 0;
   int frames_closed   = 0;
   int reads_sent      = 0;
   int results_checked = 0;
   int settings_used   = 0;

   always #HALF_PERIOD clock = ~clock;

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap(input bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // payload length after saturation at the bank size
   function automatic logic [PHASE_W-1:0] payload_len();
      return (frame_len > MAX_WORDS) ? PHASE_W'(MAX_WORDS) : PHASE_W'(frame_len);
   endfunction

   // expected result of one accepted beat, state updated in place
   function automatic void predict_deframe(input cmd_type op, input logic [WORD_W-1:0] word,
                                           input logic [IDX_FIELD_W-1:0] idx);
      word_result_type    res;
      logic [PHASE_W-1:0] len;
      logic [POS_W-1:0]   pos;
      len = payload_len();
      res = '0;
      if (op == CMD_SAMPLE) begin
         if (rx_phase == '0) begin
            if (word == start_word) rx_phase = PHASE_W'(1);
         end else if (rx_phase <= len) begin
            pos = POS_W'(rx_phase - 1'b1);
            bank_words[fill_sel][pos] = word;
            rx_phase = rx_phase + 1'b1;
         end else if (word == end_word) begin
            rx_phase = '0;
            fill_sel = fill_sel ^ 1'b1;
            res.frame_done = 1'b1;
            frames_closed++;
         end
      end else begin
         reads_sent++;
         if (idx < len) res.read_data = bank_words[fill_sel ^ 1'b1][idx];
         else res.index_error = 1'b1;
      end
      res.in_frame = (rx_phase != '0);
      expected_results.insert(expected_results.size(), res);
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return start_word;
         3: return end_word;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_marker();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // mostly indexes inside the frame, the rest anywhere
   function automatic logic [IDX_FIELD_W-1:0] random_index();
      if (payload_len() != 0 && $urandom_range(0, 9) < 7)
         return IDX_FIELD_W'($urandom_range(0, payload_len() - 1));
      return IDX_FIELD_W'($urandom_range(0, 15));
   endfunction

   // one beat on the request channel, predicted when it is taken
   task automatic send_beat(input cmd_type op, input logic [WORD_W-1:0] word,
                            input logic [IDX_FIELD_W-1:0] idx);
      int gap;
      gap = pick_gap(req_idling);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= op;
      req_bus.sample_word <= word;
      req_bus.read_index  <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_deframe(op, word, idx);
      beats_sent++;
   endtask

   task automatic send_sample(input logic [WORD_W-1:0] word);
      send_beat(CMD_SAMPLE, word, IDX_FIELD_W'($urandom()));
   endtask

   task automatic send_read(input logic [IDX_FIELD_W-1:0] idx);
      send_beat(CMD_READ, $urandom(), idx);
   endtask

   // stop offering beats and wait for every expected result
   task automatic drain_pipeline();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         REG_FRAME_LENGTH: frame_len  = value[LEN_W-1:0];
         REG_START_MARKER: start_word = value;
         REG_END_MARKER:   end_word   = value;
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] open_word,
                            input logic [WORD_W-1:0] close_word);
      drain_pipeline();
      write_reg(REG_FRAME_LENGTH, CSR_DATA_W'(len));
      write_reg(REG_START_MARKER, open_word);
      write_reg(REG_END_MARKER, close_word);
      settings_used++;
   endtask

   // feed end markers until the receiver is back to waiting for a start
   task automatic return_to_idle();
      while (rx_phase != 0) send_sample(end_word);
   endtask

   // frame with random payload, sometimes a stray word before the end marker, reads mixed in
   task automatic send_frame(input int read_pct);
      int count;
      return_to_idle();
      count = payload_len();
      send_sample(start_word);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < read_pct) send_read(random_index());
         send_sample(random_word());
      end
      if ($urandom_range(0, 9) == 0) send_sample($urandom());
      send_sample(end_word);
   endtask

   task automatic run_episode();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         send_frame(20);
      end else if (roll < 78) begin
         repeat ($urandom_range(1, 4)) send_read(random_index());
      end else if (roll < 88) begin
         // line noise while idle
         return_to_idle();
         n = $urandom_range(1, 4);
         ignored_beats += n;
         repeat (n) send_sample($urandom());
      end else begin
         // broken sequence of markers and stray words
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
               0: send_sample(start_word);
               1: send_sample(end_word);
               default: send_sample(random_word());
            endcase
         end
      end
   endtask

   task automatic test_directed_cases();
      // defaults: length 9, both markers zero; bank still cleared
      send_read(4'd0);
      send_read(4'd15);
      // equal markers: the idle phase takes the word as a start
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h1234_5678);
      // length shrunk below the current position, next word must close
      configure(5'd1, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0000);
      send_read(4'd0);
      send_read(4'd1);
      // zero length goes straight to waiting for the end marker
      configure(5'd0, 32'hFFFF_FFFF, 32'h8000_0001);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h8000_0001);
      send_read(4'd0);
      // length past the bank size saturates
      configure(5'd31, 32'h5A5A_A5A5, 32'hFFFF_FFFF);
      send_read(4'd15);
      configure(5'd16, 32'h5A5A_A5A5, 32'h0000_0000);
      send_read(4'd15);
   endtask

   // receiver holds off while beats keep coming, so the input stalls
   task automatic test_output_backpressure();
      configure(5'd4, 32'hC0DE_0001, 32'hC0DE_00FF);
      req_idling   = 1'b0;
      rsp_idling   = 1'b0;
      hold_request = 1'b1;
      send_frame(0);
      repeat (12) send_read(random_index());
      send_frame(30);
   endtask

   task automatic test_random_traffic();
      logic [LEN_W-1:0]  len;
      logic [WORD_W-1:0] open_word;
      logic [WORD_W-1:0] close_word;
      while (beats_sent - ignored_beats < BEAT_TARGET) begin
         case ($urandom_range(0, 9))
            0: len = 5'd0;
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = LEN_W'($urandom_range(17, 31));
            default: len = LEN_W'($urandom_range(2, 8));
         endcase
         open_word  = random_marker();
         close_word = ($urandom_range(0, 9) == 0) ? open_word : random_marker();
         configure(len, open_word, close_word);
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(8, 20)) run_episode();
      end
   endtask

   // result channel ready: random stalls, or a long hold on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_left = pick_gap(rsp_idling);
         rsp_bus.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none actual data %0h err %b done %b in %b",
                     $time, rsp_bus.read_data, rsp_bus.index_error, rsp_bus.frame_done,
                     rsp_bus.in_frame);
         end else begin
            oldest_result = expected_results.pop_front();
            results_checked++;
            check_field("read_data", oldest_result.read_data, rsp_bus.read_data);
            check_field("index_error", WORD_W'(oldest_result.index_error),
                        WORD_W'(rsp_bus.index_error));
            check_field("frame_done", WORD_W'(oldest_result.frame_done),
                        WORD_W'(rsp_bus.frame_done));
            check_field("in_frame", WORD_W'(oldest_result.in_frame), WORD_W'(rsp_bus.in_frame));
         end
      end
   end

   // watchdog on cycles with no beat accepted anywhere
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          psel === 1'b1 || reset === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, expected_results.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = CMD_SAMPLE;
      req_bus.sample_word = '0;
      req_bus.read_index  = '0;
      frame_len           = FRAME_LENGTH_RESET;
      start_word          = '0;
      end_word            = '0;
      rx_phase            = '0;
      fill_sel            = 1'b0;
      foreach (bank_words[b, w]) bank_words[b][w] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_output_backpressure();
      test_random_traffic();

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d beats (%0d reads, %0d frames closed) over %0d register settings",
               beats_sent, reads_sent, frames_closed, settings_used);
      $display("compared %0d results, %0d mismatches", results_checked, errors);
      if (errors == 0 && expected_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
design/mfwr_pkg.sv
design/mfwr_req_if.sv
design/mfwr_rsp_if.sv
design/mfwr_ram.sv
design/mfwr_csr.sv
design/mfwr_ctrl.sv
design/marker_framed_word_receiver_top.sv
bench/testbench.sv
